// File: rtl/core/clcd_pkg.sv
// Shared types, constants and phase decode functions for the character LCD
// 4-bit bus sequencer. No dependencies.

package clcd_pkg;

    localparam int CFG_COUNT   = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int HOLD_W      = 16;
    localparam int PHASE_IDX_W = 6;

    // Register indexes of the configuration port; also used to pick a hold time.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EN_HIGH    = 3'd0,
        REG_EN_LOW     = 3'd1,
        REG_RS_SETUP   = 3'd2,
        REG_CLEAR_WAIT = 3'd3,
        REG_HOME_WAIT  = 3'd4,
        REG_INIT_GAP   = 3'd5,
        REG_POWER_UP   = 3'd6,
        REG_INIT_FINAL = 3'd7
    } reg_idx_t;

    localparam logic [HOLD_W-1:0] CFG_RESET [CFG_COUNT] = '{
        16'd150, 16'd1000, 16'd500, 16'd3000, 16'd1500, 16'd1000, 16'd50000, 16'd5000
    };

    typedef enum logic [2:0] {
        FUNC_INIT  = 3'd0,
        FUNC_WRITE = 3'd1,
        FUNC_POS   = 3'd2,
        FUNC_CLEAR = 3'd3,
        FUNC_HOME  = 3'd4
    } func_t;

    localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] LINE1_OFFSET   = 8'h40;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_HOME       = 8'h02;
    localparam logic [PHASE_IDX_W-1:0] INIT_LAST_IDX = 6'd32;

    typedef enum logic [1:0] {
        RS_KEEP = 2'd0,
        RS_CLR  = 2'd1,
        RS_SET  = 2'd2
    } rs_op_t;

    typedef enum logic [1:0] {
        NIB_KEEP  = 2'd0,
        NIB_CONST = 2'd1,
        NIB_HI    = 2'd2,
        NIB_LO    = 2'd3
    } nib_op_t;

    typedef struct packed {
        reg_idx_t   hold_sel;
        logic       en;
        rs_op_t     rs_op;
        nib_op_t    nib_op;
        logic [3:0] nib;
        logic       last;
    } phase_desc_t;

    typedef struct packed {
        logic        load;   // capture the request byte
        logic        issue;  // produce one phase into the output register
        phase_desc_t desc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic phase_desc_t mk_desc(reg_idx_t hold_sel, logic en, rs_op_t rs_op,
                                            nib_op_t nib_op, logic [3:0] nib, logic last);
        phase_desc_t d;
        d.hold_sel = hold_sel;
        d.en       = en;
        d.rs_op    = rs_op;
        d.nib_op   = nib_op;
        d.nib      = nib;
        d.last     = last;
        return d;
    endfunction

    // Initialization run: power-up wait, three wake-up nibbles, then five
    // command bytes each preceded by a gap, then a final wait.
    function automatic phase_desc_t init_desc(logic [PHASE_IDX_W-1:0] idx);
        phase_desc_t d;
        d = mk_desc(REG_EN_LOW, 1'b0, RS_KEEP, NIB_KEEP, 4'h0, 1'b0);
        case (idx)
            6'd0:  d = mk_desc(REG_POWER_UP, 1'b0, RS_CLR, NIB_CONST, 4'h0, 1'b0);
            6'd1:  d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h2, 1'b0);
            6'd3:  d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h2, 1'b0);
            6'd5:  d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h8, 1'b0);
            6'd7, 6'd12, 6'd17, 6'd22, 6'd27:
                d = mk_desc(REG_INIT_GAP, 1'b0, RS_KEEP, NIB_KEEP, 4'h0, 1'b0);
            6'd8:  d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h0, 1'b0);
            6'd10: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'hC, 1'b0);
            6'd13: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h0, 1'b0);
            6'd15: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h1, 1'b0);
            6'd18: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h0, 1'b0);
            6'd20: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h6, 1'b0);
            6'd23: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h0, 1'b0);
            6'd25: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h2, 1'b0);
            6'd28: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'h0, 1'b0);
            6'd30: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_CONST, 4'hF, 1'b0);
            6'd32: d = mk_desc(REG_INIT_FINAL, 1'b0, RS_KEEP, NIB_KEEP, 4'h0, 1'b1);
            default: d = mk_desc(REG_EN_LOW, 1'b0, RS_KEEP, NIB_KEEP, 4'h0, 1'b0);
        endcase
        return d;
    endfunction

    // Single-byte runs: RS setup, two strobed nibbles, and for clear and home
    // a trailing wait.
    function automatic phase_desc_t byte_desc(func_t func, logic [PHASE_IDX_W-1:0] idx);
        phase_desc_t d;
        logic        short_run;
        short_run = (func == FUNC_WRITE) || (func == FUNC_POS);
        case (idx)
            6'd0: d = mk_desc(REG_RS_SETUP, 1'b0,
                              (func == FUNC_WRITE) ? RS_SET : RS_CLR, NIB_KEEP, 4'h0, 1'b0);
            6'd1: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_HI, 4'h0, 1'b0);
            6'd2: d = mk_desc(REG_EN_LOW, 1'b0, RS_KEEP, NIB_KEEP, 4'h0, 1'b0);
            6'd3: d = mk_desc(REG_EN_HIGH, 1'b1, RS_KEEP, NIB_LO, 4'h0, 1'b0);
            6'd4: d = mk_desc(REG_EN_LOW, 1'b0, RS_KEEP, NIB_KEEP, 4'h0, short_run);
            default: d = mk_desc((func == FUNC_CLEAR) ? REG_CLEAR_WAIT : REG_HOME_WAIT,
                                 1'b0, RS_KEEP, NIB_KEEP, 4'h0, 1'b1);
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/clcd_ifs.sv
// Channel interfaces of the character LCD sequencer: request, phase and
// configuration write. Depends on clcd_pkg.

interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] char_code;
    logic       line;
    logic [5:0] column;

    modport source (output valid, func, char_code, line, column, input ready);
    modport sink   (input valid, func, char_code, line, column, output ready);
endinterface

interface clcd_phase_if;
    logic                        valid;
    logic                        ready;
    logic                        rs_level;
    logic [3:0]                  data_nibble;
    logic                        enable_level;
    logic [clcd_pkg::HOLD_W-1:0] hold_us;
    logic                        last;

    modport source (output valid, rs_level, data_nibble, enable_level, hold_us, last,
                    input ready);
    modport sink   (input valid, rs_level, data_nibble, enable_level, hold_us, last,
                    output ready);
endinterface

interface clcd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [clcd_pkg::CFG_IDX_W-1:0] index;
    logic [clcd_pkg::HOLD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/clcd_datapath.sv
// Datapath: hold-time registers, pin state, request byte and phase output
// register. Depends on clcd_pkg and clcd_ifs.

module clcd_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  clcd_pkg::ctrl_cmd_t   cmd,
    output clcd_pkg::dp_status_t  status,
    input  logic [2:0]            func,
    input  logic [7:0]            char_code,
    input  logic                  line,
    input  logic [5:0]            column,
    clcd_cfg_if.sink              cfg,
    clcd_phase_if.source          phase
);

    logic [clcd_pkg::HOLD_W-1:0] cfg_reg [clcd_pkg::CFG_COUNT];
    logic                        rs_pin_reg;
    logic                        rs_pin_next;
    logic [3:0]                  data_pins_reg;
    logic [3:0]                  data_pins_next;
    logic [7:0]                  byte_reg;
    logic [7:0]                  byte_next;
    logic                        out_valid_reg;
    logic                        out_rs_reg;
    logic [3:0]                  out_nib_reg;
    logic                        out_en_reg;
    logic [clcd_pkg::HOLD_W-1:0] out_hold_reg;
    logic                        out_last_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < clcd_pkg::CFG_COUNT; i++)
            begin
                cfg_reg[i] <= clcd_pkg::CFG_RESET[i];
            end
        end
        else if (cfg.valid)
        begin
            cfg_reg[cfg.index] <= cfg.data;
        end
    end

    always_comb
    begin
        case (clcd_pkg::func_t'(func))
            clcd_pkg::FUNC_WRITE: byte_next = char_code;
            clcd_pkg::FUNC_POS:   byte_next = clcd_pkg::CMD_SET_DDRAM
                                              | (line ? clcd_pkg::LINE1_OFFSET : 8'h00)
                                              | {2'b00, column};
            clcd_pkg::FUNC_CLEAR: byte_next = clcd_pkg::CMD_CLEAR;
            clcd_pkg::FUNC_HOME:  byte_next = clcd_pkg::CMD_HOME;
            default:              byte_next = 8'h00;
        endcase
    end

    always_comb
    begin
        case (cmd.desc.rs_op)
            clcd_pkg::RS_CLR: rs_pin_next = 1'b0;
            clcd_pkg::RS_SET: rs_pin_next = 1'b1;
            default:          rs_pin_next = rs_pin_reg;
        endcase
        case (cmd.desc.nib_op)
            clcd_pkg::NIB_CONST: data_pins_next = cmd.desc.nib;
            clcd_pkg::NIB_HI:    data_pins_next = byte_reg[7:4];
            clcd_pkg::NIB_LO:    data_pins_next = byte_reg[3:0];
            default:             data_pins_next = data_pins_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_pin_reg    <= 1'b0;
            data_pins_reg <= 4'h0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.issue)
            begin
                rs_pin_reg    <= rs_pin_next;
                data_pins_reg <= data_pins_next;
                out_valid_reg <= 1'b1;
            end
            else if (phase.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= byte_next;
        end
        if (cmd.issue)
        begin
            out_rs_reg   <= rs_pin_next;
            out_nib_reg  <= data_pins_next;
            out_en_reg   <= cmd.desc.en;
            out_hold_reg <= cfg_reg[cmd.desc.hold_sel];
            out_last_reg <= cmd.desc.last;
        end
    end

    assign status.out_free    = !out_valid_reg || phase.ready;
    assign phase.valid        = out_valid_reg;
    assign phase.rs_level     = out_rs_reg;
    assign phase.data_nibble  = out_nib_reg;
    assign phase.enable_level = out_en_reg;
    assign phase.hold_us      = out_hold_reg;
    assign phase.last         = out_last_reg;

    // A phase is never produced over one that the receiver has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (!out_valid_reg || phase.ready))
        else $error("phase issued while output register is occupied");

endmodule

// File: rtl/core/clcd_ctrl.sv
// Controller: accepts requests and steps through the phase sequence of each
// run. Depends on clcd_pkg.

module clcd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [2:0]           req_func,
    input  clcd_pkg::dp_status_t status,
    output clcd_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    clcd_pkg::func_t                  func_reg;
    clcd_pkg::func_t                  func_next;
    logic [clcd_pkg::PHASE_IDX_W-1:0] idx_reg;
    logic [clcd_pkg::PHASE_IDX_W-1:0] idx_next;
    logic                             accept;
    logic                             known;
    clcd_pkg::phase_desc_t            desc;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign known     = (req_func <= 3'(clcd_pkg::FUNC_HOME));

    always_comb
    begin
        if (func_reg == clcd_pkg::FUNC_INIT)
        begin
            desc = clcd_pkg::init_desc(idx_reg);
        end
        else
        begin
            desc = clcd_pkg::byte_desc(func_reg, idx_reg);
        end
    end

    assign cmd.load  = accept;
    assign cmd.issue = (state_reg == ST_RUN) && status.out_free;
    assign cmd.desc  = desc;

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && known)
                begin
                    state_next = ST_RUN;
                    func_next  = clcd_pkg::func_t'(req_func);
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (cmd.issue)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (desc.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            func_reg  <= clcd_pkg::FUNC_INIT;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
            idx_reg   <= idx_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (idx_reg <= clcd_pkg::INIT_LAST_IDX))
        else $error("phase index ran past the longest run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && known) |=> (state_reg == ST_RUN) && (idx_reg == '0))
        else $error("known request did not start a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && desc.last) |=> (state_reg == ST_IDLE))
        else $error("run did not end after its last phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !known) |=> (state_reg == ST_IDLE))
        else $error("unknown request started a run");

endmodule

// File: rtl/core/char_lcd_4bit_bus_sequencer.sv
// Top level of the character LCD 4-bit bus sequencer: joins the controller
// and the datapath. Depends on clcd_pkg, clcd_ifs, clcd_ctrl and clcd_datapath.
//
// Usage: a request (init, write character, set position, clear, home) is
// handed over on the req channel; the block answers with a run of pin phases
// on the phase channel, each giving RS, D4..D7, enable and a hold time in
// microseconds, with last set on the final phase of the run. Hold times come
// from eight 16-bit registers written over the cfg channel, which is always
// ready; write them only while no run is in progress.
// Timing: a request is taken when the block is idle; the controller then
// enters its run state and issues the first phase into the output register
// once that register is free. Then one phase transfer per cycle follows while
// the receiver keeps ready high: 33 phases for init, 5 for write character and
// set position, 6 for clear and home, stepped by the controller's phase counter.
// Requests with an unknown code are taken and produce no phases.
// When the receiver stalls, the output register holds its phase and the
// sequence waits; the next request may be taken while the last phase of a run
// is still waiting. Reset empties the output register, drives RS and data
// state low and loads the default hold times.

module char_lcd_4bit_bus_sequencer
(
    input  logic         clk,
    input  logic         rst_n,
    clcd_req_if.sink     req,
    clcd_phase_if.source phase,
    clcd_cfg_if.sink     cfg
);

    // Command and status between the controller and the datapath.
    clcd_pkg::ctrl_cmd_t  cmd;
    clcd_pkg::dp_status_t status;

    clcd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_func  (req.func),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath captures the request byte in the same cycle the request
    // transfer happens, so it reads the request payload directly.
    clcd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .func      (req.func),
        .char_code (req.char_code),
        .line      (req.line),
        .column    (req.column),
        .cfg       (cfg),
        .phase     (phase)
    );

endmodule
